FILE: rtl/core/srd_pkg.sv
// Package for the sync record deframer: byte roles, sync phases, constants
// and the structs passed between the framer and the top level.
// No dependencies.
`timescale 1ns / 1ps

package srd_pkg;

    localparam logic [7:0] SYNC_FIRST       = 8'hA3;
    localparam logic [7:0] SYNC_SECOND      = 8'h95;
    localparam logic [7:0] HEADER_BYTES     = 8'd3;
    localparam logic [7:0] MIN_DEF_LENGTH   = 8'd5;
    localparam logic [7:0] PAYLOAD_IDX_MAX  = 8'd255;
    localparam logic [7:0] DEF_TYPE_RESET   = 8'd128;
    localparam logic [7:0] DEF_LENGTH_RESET = 8'd89;

    localparam logic CFG_DEF_TYPE   = 1'b0;
    localparam logic CFG_DEF_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        ROLE_IGNORED,
        ROLE_SYNC,
        ROLE_TYPE,
        ROLE_PAYLOAD,
        ROLE_MISSING
    } t_role;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC1,
        PH_TYPE
    } t_phase;

    typedef struct packed {
        t_role      role;
        logic [7:0] rtype;
        logic       is_def;
        logic       rec_end;
        logic [1:0] ign_inc;
        logic [1:0] miss_inc;
        logic [1:0] rec_inc;
    } t_step;

    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } t_table_wr;

endpackage

FILE: rtl/core/sync_record_deframer_core.sv
// Top level of the sync record deframer: input and result registers, config
// registers, length table RAM and counters. Uses srd_pkg, srd_ram,
// srd_sat_counter and srd_framer.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_data_byte
//   result    out        o_valid / i_stall    o_echo_byte .. o_records_total
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One byte per cycle unless i_stall holds; path: input register, then result register.
// The length table read is issued when a byte is accepted, so the step logic sees
// the registered RAM data in the next cycle.
// Reset clears control state and all definition valid bits; the table
// contents stay undefined and need no clearing pass.
// A stall on the result side holds the result and passes back to o_stall.
`timescale 1ns / 1ps

module sync_record_deframer_core import srd_pkg::*; #(
    parameter int TYPE_COUNT  = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_echo_byte,
    output logic [2:0]  o_byte_role,
    output logic [7:0]  o_record_type,
    output logic        o_is_definition,
    output logic        o_record_end,
    output logic [31:0] o_ignored_total,
    output logic [31:0] o_missing_total,
    output logic [31:0] o_records_total
);

    localparam int TIDX_W = $clog2(TYPE_COUNT);

    logic [7:0] r_def_type_val;
    logic [7:0] r_def_len_val;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_out_echo;
    t_role      r_out_role;
    logic [7:0] r_out_type;
    logic       r_out_def;
    logic       r_out_end;

    logic       out_free;
    logic       advance;
    logic       in_xfer;
    logic [7:0] table_len;
    t_step      step;
    t_table_wr  tbl_wr;

    logic [COUNT_WIDTH-1:0] ign_count;
    logic [COUNT_WIDTH-1:0] miss_count;
    logic [COUNT_WIDTH-1:0] rec_count;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_xfer  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_type_val <= DEF_TYPE_RESET;
            r_def_len_val  <= DEF_LENGTH_RESET;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_DEF_TYPE) begin
                r_def_type_val <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_DEF_LENGTH) begin
                r_def_len_val <= i_cfg_data;
            end
        end
    end

    // hold the input byte until the step logic takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_echo <= r_in_byte;
            r_out_role <= step.role;
            r_out_type <= step.rtype;
            r_out_def  <= step.is_def;
            r_out_end  <= step.rec_end;
        end
    end

    srd_ram #(
        .WIDTH (8),
        .DEPTH (TYPE_COUNT)
    ) u_len_table (
        .i_clk   (i_clk),
        .i_we    (advance && tbl_wr.we),
        .i_waddr (tbl_wr.addr[TIDX_W-1:0]),
        .i_wdata (tbl_wr.data),
        .i_re    (in_xfer),
        .i_raddr (i_data_byte[TIDX_W-1:0]),
        .o_rdata (table_len)
    );

    srd_framer #(
        .TYPE_COUNT (TYPE_COUNT)
    ) u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (r_in_byte),
        .i_table_len (table_len),
        .i_def_type  (r_def_type_val),
        .i_def_len   (r_def_len_val),
        .o_step      (step),
        .o_wr        (tbl_wr)
    );

    srd_sat_counter #(.WIDTH (COUNT_WIDTH)) u_ign_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_inc   (step.ign_inc),
        .o_count (ign_count)
    );

    srd_sat_counter #(.WIDTH (COUNT_WIDTH)) u_miss_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_inc   (step.miss_inc),
        .o_count (miss_count)
    );

    srd_sat_counter #(.WIDTH (COUNT_WIDTH)) u_rec_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_inc   (step.rec_inc),
        .o_count (rec_count)
    );

    // counters advance with the result register, so they always match it
    assign o_valid         = r_out_valid;
    assign o_echo_byte     = r_out_echo;
    assign o_byte_role     = r_out_role;
    assign o_record_type   = r_out_type;
    assign o_is_definition = r_out_def;
    assign o_record_end    = r_out_end;
    assign o_ignored_total = 32'(ign_count);
    assign o_missing_total = 32'(miss_count);
    assign o_records_total = 32'(rec_count);

endmodule

FILE: rtl/core/srd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module srd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/srd_sat_counter.sv
// Saturating event counter with a small increment.
// No dependencies.
`timescale 1ns / 1ps

module srd_sat_counter #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [1:0]       i_inc,
    output logic [WIDTH-1:0] o_count
);

    localparam logic [WIDTH-1:0] COUNT_MAX = {WIDTH{1'b1}};

    logic [WIDTH-1:0] r_count;
    logic [WIDTH-1:0] n_count;

    always_comb begin
        if (r_count > COUNT_MAX - WIDTH'(i_inc)) begin
            n_count = COUNT_MAX;
        end else begin
            n_count = r_count + WIDTH'(i_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

FILE: rtl/core/srd_framer.sv
// Framing state machine: sync hunt, record tracking, definition capture and
// the per-type valid bits. Uses srd_pkg; length table data comes from outside.
`timescale 1ns / 1ps

module srd_framer import srd_pkg::*; #(
    parameter int TYPE_COUNT = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_table_len,
    input  logic [7:0] i_def_type,
    input  logic [7:0] i_def_len,
    output t_step      o_step,
    output t_table_wr  o_wr
);

    localparam int TIDX_W = $clog2(TYPE_COUNT);

    t_phase                r_phase,     n_phase;
    logic                  r_in_record, n_in_record;
    logic [7:0]            r_cur_type,  n_cur_type;
    logic                  r_cur_def,   n_cur_def;
    logic [7:0]            r_bytes_left, n_bytes_left;
    logic [7:0]            r_pay_idx,   n_pay_idx;
    logic [7:0]            r_cap_type,  n_cap_type;
    logic [7:0]            r_cap_len,   n_cap_len;
    logic [TYPE_COUNT-1:0] r_def_valid;

    logic       byte_in_range;
    logic       cap_in_range;
    logic [7:0] def_len;
    logic [7:0] left_dec;

    assign byte_in_range = (9'(i_byte) < 9'(TYPE_COUNT));
    assign def_len  = (i_def_len < MIN_DEF_LENGTH) ? MIN_DEF_LENGTH : i_def_len;
    assign left_dec = (r_bytes_left != 8'd0) ? r_bytes_left - 8'd1 : r_bytes_left;

    always_comb begin
        n_phase      = r_phase;
        n_in_record  = r_in_record;
        n_cur_type   = r_cur_type;
        n_cur_def    = r_cur_def;
        n_bytes_left = r_bytes_left;
        n_pay_idx    = r_pay_idx;
        n_cap_type   = r_cap_type;
        n_cap_len    = r_cap_len;
        o_step       = '{role: ROLE_IGNORED, rtype: 8'd0, is_def: 1'b0, rec_end: 1'b0,
                         ign_inc: 2'd0, miss_inc: 2'd0, rec_inc: 2'd0};
        o_wr         = '{we: 1'b0, addr: 8'd0, data: 8'd0};
        cap_in_range = 1'b0;

        if (r_in_record) begin
            o_step.role   = ROLE_PAYLOAD;
            o_step.rtype  = r_cur_type;
            o_step.is_def = r_cur_def;
            if (r_cur_def && r_pay_idx == 8'd0) begin
                n_cap_type = i_byte;
            end
            if (r_cur_def && r_pay_idx == 8'd1) begin
                n_cap_len = i_byte;
            end
            if (r_pay_idx < PAYLOAD_IDX_MAX) begin
                n_pay_idx = r_pay_idx + 8'd1;
            end
            n_bytes_left = left_dec;
            if (left_dec == 8'd0) begin
                o_step.rec_end = 1'b1;
                o_step.rec_inc = 2'd1;
                n_in_record    = 1'b0;
                cap_in_range   = (9'(n_cap_type) < 9'(TYPE_COUNT));
                o_wr.we        = r_cur_def && cap_in_range;
                o_wr.addr      = n_cap_type;
                o_wr.data      = n_cap_len;
            end
        end else begin
            case (r_phase)
                PH_SYNC1: begin
                    if (i_byte == SYNC_SECOND) begin
                        n_phase     = PH_TYPE;
                        o_step.role = ROLE_SYNC;
                    end else begin
                        n_phase        = PH_HUNT;
                        o_step.ign_inc = 2'd2;
                    end
                end
                PH_TYPE: begin
                    n_phase      = PH_HUNT;
                    o_step.rtype = i_byte;
                    n_cur_type   = i_byte;
                    n_pay_idx    = 8'd0;
                    n_cap_type   = 8'd0;
                    n_cap_len    = 8'd0;
                    if (i_byte == i_def_type) begin
                        o_step.role   = ROLE_TYPE;
                        o_step.is_def = 1'b1;
                        n_cur_def     = 1'b1;
                        n_in_record   = 1'b1;
                        n_bytes_left  = def_len - HEADER_BYTES;
                    end else begin
                        n_cur_def = 1'b0;
                        if (!(byte_in_range && r_def_valid[i_byte[TIDX_W-1:0]]
                              && i_table_len >= HEADER_BYTES)) begin
                            o_step.role     = ROLE_MISSING;
                            o_step.miss_inc = 2'd1;
                        end else begin
                            o_step.role = ROLE_TYPE;
                            if (i_table_len == HEADER_BYTES) begin
                                o_step.rec_end = 1'b1;
                                o_step.rec_inc = 2'd1;
                            end else begin
                                n_in_record  = 1'b1;
                                n_bytes_left = i_table_len - HEADER_BYTES;
                            end
                        end
                    end
                end
                default: begin
                    if (i_byte == SYNC_FIRST) begin
                        n_phase     = PH_SYNC1;
                        o_step.role = ROLE_SYNC;
                    end else begin
                        n_phase        = PH_HUNT;
                        o_step.ign_inc = 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_in_record  <= 1'b0;
            r_cur_type   <= 8'd0;
            r_cur_def    <= 1'b0;
            r_bytes_left <= 8'd0;
            r_pay_idx    <= 8'd0;
            r_cap_type   <= 8'd0;
            r_cap_len    <= 8'd0;
            r_def_valid  <= '0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_in_record  <= n_in_record;
            r_cur_type   <= n_cur_type;
            r_cur_def    <= n_cur_def;
            r_bytes_left <= n_bytes_left;
            r_pay_idx    <= n_pay_idx;
            r_cap_type   <= n_cap_type;
            r_cap_len    <= n_cap_len;
            if (o_wr.we) begin
                r_def_valid[o_wr.addr[TIDX_W-1:0]] <= 1'b1;
            end
        end
    end

endmodule

FILE: tb/sync_record_deframer_core_tb.sv
// Self-checking testbench for sync_record_deframer_core: drives a log byte stream,
// predicts every tagged result with a behavioral framer and compares each transfer.
// Depends on srd_pkg and the RTL of sync_record_deframer_core.
`timescale 1ns / 1ps

module sync_record_deframer_core_tb;
    import srd_pkg::*;

    localparam int TYPE_COUNT  = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [7:0]  echo;
        t_role       role;
        logic [7:0]  rtype;
        logic        is_def;
        logic        rec_end;
        logic [31:0] ign;
        logic [31:0] miss;
        logic [31:0] recs;
    } frame_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_echo_byte;
    logic [2:0]  o_byte_role;
    logic [7:0]  o_record_type;
    logic        o_is_definition;
    logic        o_record_end;
    logic [31:0] o_ignored_total;
    logic [31:0] o_missing_total;
    logic [31:0] o_records_total;

    sync_record_deframer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_echo_byte     (o_echo_byte),
        .o_byte_role     (o_byte_role),
        .o_record_type   (o_record_type),
        .o_is_definition (o_is_definition),
        .o_record_end    (o_record_end),
        .o_ignored_total (o_ignored_total),
        .o_missing_total (o_missing_total),
        .o_records_total (o_records_total)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // behavioral framer state
    logic [7:0]  cfg_def_type;
    logic [7:0]  cfg_def_len;
    t_phase      fr_phase;
    logic        fr_in_rec;
    logic [7:0]  fr_type;
    logic [7:0]  fr_left;
    logic [7:0]  fr_pidx;
    logic [7:0]  fr_cap_type;
    logic [7:0]  fr_cap_len;
    logic        fr_is_def;
    logic [7:0]  len_table [TYPE_COUNT];
    logic        len_valid [TYPE_COUNT];
    logic [31:0] ignored_cnt;
    logic [31:0] missing_cnt;
    logic [31:0] record_cnt;

    frame_result_t expected_results [$];
    frame_result_t predicted;
    frame_result_t oldest;

    int cycle_count = 0;
    int errors = 0;
    int results_seen = 0;
    int records_seen = 0;
    int missing_seen = 0;
    int bytes_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;

    function automatic logic [31:0] sat_inc(logic [31:0] c, logic [1:0] n);
        logic [32:0] s;
        s = {1'b0, c} + n;
        return s[32] ? '1 : s[31:0];
    endfunction

    task automatic reset_framer;
        cfg_def_type = DEF_TYPE_RESET;
        cfg_def_len  = DEF_LENGTH_RESET;
        fr_phase     = PH_HUNT;
        fr_in_rec    = 1'b0;
        fr_type      = '0;
        fr_left      = '0;
        fr_pidx      = '0;
        fr_cap_type  = '0;
        fr_cap_len   = '0;
        fr_is_def    = 1'b0;
        for (int t = 0; t < TYPE_COUNT; t++) begin
            len_table[t] = '0;
            len_valid[t] = 1'b0;
        end
        ignored_cnt = '0;
        missing_cnt = '0;
        record_cnt  = '0;
    endtask

    task automatic frame_byte(input logic [7:0] b, output frame_result_t r);
        logic [7:0] eff_len;
        r = '0;
        r.echo = b;
        r.role = ROLE_IGNORED;
        if (fr_in_rec) begin
            r.role   = ROLE_PAYLOAD;
            r.rtype  = fr_type;
            r.is_def = fr_is_def;
            if (fr_is_def) begin
                if (fr_pidx == 8'd0) fr_cap_type = b;
                else if (fr_pidx == 8'd1) fr_cap_len = b;
            end
            if (fr_pidx != PAYLOAD_IDX_MAX) fr_pidx = fr_pidx + 8'd1;
            if (fr_left != 8'd0) fr_left = fr_left - 8'd1;
            if (fr_left == 8'd0) begin
                r.rec_end  = 1'b1;
                fr_in_rec  = 1'b0;
                record_cnt = sat_inc(record_cnt, 2'd1);
                if (fr_is_def && int'(fr_cap_type) < TYPE_COUNT) begin
                    len_table[fr_cap_type] = fr_cap_len;
                    len_valid[fr_cap_type] = 1'b1;
                end
            end
        end else begin
            case (fr_phase)
                PH_HUNT: begin
                    if (b == SYNC_FIRST) begin
                        fr_phase = PH_SYNC1;
                        r.role   = ROLE_SYNC;
                    end else begin
                        ignored_cnt = sat_inc(ignored_cnt, 2'd1);
                    end
                end
                PH_SYNC1: begin
                    if (b == SYNC_SECOND) begin
                        fr_phase = PH_TYPE;
                        r.role   = ROLE_SYNC;
                    end else begin
                        fr_phase    = PH_HUNT;
                        ignored_cnt = sat_inc(ignored_cnt, 2'd2);
                    end
                end
                default: begin
                    fr_phase    = PH_HUNT;
                    r.rtype     = b;
                    fr_type     = b;
                    fr_pidx     = '0;
                    fr_cap_type = '0;
                    fr_cap_len  = '0;
                    if (b == cfg_def_type) begin
                        eff_len   = (cfg_def_len < MIN_DEF_LENGTH) ? MIN_DEF_LENGTH : cfg_def_len;
                        r.role    = ROLE_TYPE;
                        r.is_def  = 1'b1;
                        fr_is_def = 1'b1;
                        fr_in_rec = 1'b1;
                        fr_left   = eff_len - HEADER_BYTES;
                    end else begin
                        fr_is_def = 1'b0;
                        if (int'(b) < TYPE_COUNT && len_valid[b]
                                && len_table[b] >= HEADER_BYTES) begin
                            r.role = ROLE_TYPE;
                            if (len_table[b] == HEADER_BYTES) begin
                                r.rec_end  = 1'b1;
                                record_cnt = sat_inc(record_cnt, 2'd1);
                            end else begin
                                fr_in_rec = 1'b1;
                                fr_left   = len_table[b] - HEADER_BYTES;
                            end
                        end else begin
                            r.role      = ROLE_MISSING;
                            missing_cnt = sat_inc(missing_cnt, 2'd1);
                        end
                    end
                end
            endcase
        end
        r.ign  = ignored_cnt;
        r.miss = missing_cnt;
        r.recs = record_cnt;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_framer();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DEF_TYPE) cfg_def_type = i_cfg_data;
                else cfg_def_len = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                frame_byte(i_data_byte, predicted);
                expected_results.push_back(predicted);
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp, act);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            results_seen++;
            if (o_record_end === 1'b1) records_seen++;
            if (o_byte_role === ROLE_MISSING) missing_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual echo %0h",
                         $time, o_echo_byte);
                errors++;
            end else begin
                oldest = expected_results.pop_front();
                check_field("echo_byte", oldest.echo, o_echo_byte);
                check_field("byte_role", oldest.role, o_byte_role);
                check_field("record_type", oldest.rtype, o_record_type);
                check_field("is_definition", oldest.is_def, o_is_definition);
                check_field("record_end", oldest.rec_end, o_record_end);
                check_field("ignored_total", oldest.ign, o_ignored_total);
                check_field("missing_total", oldest.miss, o_missing_total);
                check_field("records_total", oldest.recs, o_records_total);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return SYNC_FIRST;
        if (r == 1) return SYNC_SECOND;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_type();
        if ($urandom_range(0, 99) < 80) return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'($urandom_range(0, 2));
        if (r < 25) return HEADER_BYTES;
        if (r < 97) return 8'($urandom_range(4, 12));
        return 8'($urandom_range(13, 255));
    endfunction

    // header, type, then as many payload bytes as the framer now expects
    task automatic send_record(input logic [7:0] rec_type, input logic [7:0] def_type,
                               input logic [7:0] def_len);
        int         n;
        logic       is_def;
        logic [7:0] b;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(rec_type);
        n = fr_in_rec ? int'(fr_left) : 0;
        is_def = fr_is_def;
        for (int i = 0; i < n; i++) begin
            if (is_def && i == 0) b = def_type;
            else if (is_def && i == 1) b = def_len;
            else b = rand_byte();
            send_byte(b);
        end
    endtask

    task automatic flush_framing;
        logic [7:0] b;
        while (fr_in_rec || fr_phase != PH_HUNT) begin
            b = 8'($urandom_range(0, 255));
            if (b == SYNC_FIRST) b = 8'h00;
            send_byte(b);
        end
    endtask

    task automatic settle;
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_config(input logic idx, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_random_config;
        write_config(CFG_DEF_TYPE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 80) write_config(CFG_DEF_LENGTH, 8'($urandom_range(5, 9)));
        else write_config(CFG_DEF_LENGTH, 8'($urandom_range(10, 40)));
    endtask

    task automatic random_traffic(input int target);
        int start;
        int sel;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                flush_framing();
                send_record(pick_type(), 8'h00, 8'h00);
            end else if (sel < 65) begin
                flush_framing();
                send_record(cfg_def_type, pick_type(), pick_length());
            end else if (sel < 75) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else if (sel < 85) begin
                send_byte(SYNC_FIRST);
                send_byte(rand_byte());
            end else if (sel < 95) begin
                // truncated definition, finished later by filler
                flush_framing();
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(cfg_def_type);
                send_byte(pick_type());
            end else begin
                repeat ($urandom_range(2, 5)) send_byte(SYNC_FIRST);
            end
        end
    endtask

    task automatic test_reset_config;
        send_record(DEF_TYPE_RESET, 8'h10, HEADER_BYTES);
        send_record(8'h10, 8'h00, 8'h00);
        send_record(8'h7F, 8'h00, 8'h00);
    endtask

    task automatic test_sync_hunt;
        send_byte(8'h00);
        send_byte(8'hFF);
        // second header byte fails and is not taken as a new first byte
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        send_record(8'h11, 8'h00, 8'h00);
    endtask

    task automatic test_definitions;
        send_record(8'h00, 8'hFF, 8'd2);
        send_record(8'hFF, 8'h00, 8'h00);
        send_record(8'h00, 8'h20, 8'd4);
        send_record(8'h20, 8'h00, 8'h00);
        send_record(8'h00, 8'h20, HEADER_BYTES);
        send_record(8'h20, 8'h00, 8'h00);
    endtask

    task automatic test_long_records;
        send_record(8'hFF, 8'h21, 8'hFF);
        send_record(8'h21, 8'h00, 8'h00);
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 400;
        random_traffic(150);
        settle();
    endtask

    task automatic test_random_mix(input int send_pct, input int recv_pct, input int target);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (3) begin
            settle();
            write_random_config();
            random_traffic(target / 3);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_DEF_TYPE;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 28;
        recv_idle_pct = 68;
        test_reset_config();
        settle();
        write_config(CFG_DEF_TYPE, 8'h00);
        write_config(CFG_DEF_LENGTH, MIN_DEF_LENGTH);
        test_sync_hunt();
        test_definitions();
        settle();
        write_config(CFG_DEF_TYPE, 8'hFF);
        write_config(CFG_DEF_LENGTH, 8'hFF);
        test_long_records();
        settle();
        write_config(CFG_DEF_TYPE, 8'h40);
        write_config(CFG_DEF_LENGTH, 8'd6);
        test_backpressure();

        test_random_mix(28, 68, 350);
        test_random_mix(68, 28, 350);
        test_random_mix(0, 0, 350);

        settle();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d byte transfers, %0d framed records, %0d types without definition,",
                 results_seen, records_seen, missing_seen);
        $display("across three idle mixes, a long output hold-off and several register settings.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
